>>> design/qrs_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared widths, payload types and the job format passed from the front end
// to the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qrs_pkg;

   localparam int COEF_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int DISC_WIDTH = 2 * COEF_WIDTH + 1;
   localparam int SQRT_WIDTH = COEF_WIDTH + 1;

   localparam logic [1:0] COUNT_NONE = 2'd0;
   localparam logic [1:0] COUNT_ONE  = 2'd1;
   localparam logic [1:0] COUNT_TWO  = 2'd2;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_LINEAR,
      MODE_ONE,
      MODE_TWO
   } mode_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] coef_a;
      logic signed [COEF_WIDTH-1:0] coef_b;
      logic signed [COEF_WIDTH-1:0] coef_c;
   } req_type;

   typedef struct packed {
      logic [1:0]                   root_count;
      logic signed [COEF_WIDTH-1:0] root_first;
      logic signed [COEF_WIDTH-1:0] root_second;
      logic                         saturated;
   } rsp_type;

   typedef struct packed {
      mode_type                mode;
      logic [DISC_WIDTH-1:0]   disc;
      logic                    b_neg;
      logic [COEF_WIDTH-1:0]   b_mag;
      logic                    a_neg;
      logic [COEF_WIDTH:0]     dvs;
      logic                    lin_neg;
      logic [COEF_WIDTH-1:0]   c_mag;
   } job_type;

endpackage

>>> design/qrs_front.sv
// ----------------------------------------------------------------------------
// Quadratic root solver front end
// Accepts coefficient requests, forms b*b and 4ac, classifies the equation
// and hands a job with the exact discriminant to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qrs_pkg::req_type req_data,
   output logic             job_valid,
   output qrs_pkg::job_type job_data,
   input  logic             job_full
);
   import qrs_pkg::*;

   localparam int W  = COEF_WIDTH;
   localparam int PW = 2 * W;
   localparam int DW = DISC_WIDTH;

   typedef struct packed {
      logic         a_neg;
      logic         b_neg;
      logic         c_neg;
      logic [W-1:0] a_mag;
      logic [W-1:0] b_mag;
      logic [W-1:0] c_mag;
   } sign_mag_type;

   logic         adv;
   logic         a_valid_ff, b_valid_ff, c_valid_ff;
   sign_mag_type sm_a_ff, sm_a_in, sm_b_ff;
   logic [PW-1:0] bb_ff, bb_in, ac_ff, ac_in;
   job_type      job_ff, job_in;

   logic [DW-1:0] bbx, ac4;
   logic          a_zero, b_zero, ac_neg;

   assign adv       = !(c_valid_ff && job_full);
   assign req_stall = !adv;
   assign job_valid = c_valid_ff;
   assign job_data  = job_ff;

   always_comb begin
      sm_a_in.a_neg = req_data.coef_a[W-1];
      sm_a_in.b_neg = req_data.coef_b[W-1];
      sm_a_in.c_neg = req_data.coef_c[W-1];
      sm_a_in.a_mag = req_data.coef_a[W-1] ? W'(-req_data.coef_a) : W'(req_data.coef_a);
      sm_a_in.b_mag = req_data.coef_b[W-1] ? W'(-req_data.coef_b) : W'(req_data.coef_b);
      sm_a_in.c_mag = req_data.coef_c[W-1] ? W'(-req_data.coef_c) : W'(req_data.coef_c);
   end

   assign bb_in = PW'(sm_a_ff.b_mag) * PW'(sm_a_ff.b_mag);
   assign ac_in = PW'(sm_a_ff.a_mag) * PW'(sm_a_ff.c_mag);

   always_comb begin
      bbx    = DW'(bb_ff);
      ac4    = DW'({ac_ff, 2'b00});
      a_zero = (sm_b_ff.a_mag == '0);
      b_zero = (sm_b_ff.b_mag == '0);
      ac_neg = (sm_b_ff.a_neg != sm_b_ff.c_neg) && (sm_b_ff.c_mag != '0);

      job_in.disc    = '0;
      job_in.mode    = MODE_NONE;
      job_in.b_neg   = sm_b_ff.b_neg;
      job_in.b_mag   = sm_b_ff.b_mag;
      job_in.a_neg   = sm_b_ff.a_neg;
      job_in.dvs     = a_zero ? {1'b0, sm_b_ff.b_mag} : {sm_b_ff.a_mag, 1'b0};
      job_in.lin_neg = (sm_b_ff.c_mag != '0) && (sm_b_ff.c_neg == sm_b_ff.b_neg);
      job_in.c_mag   = sm_b_ff.c_mag;

      if (a_zero) begin
         job_in.mode = b_zero ? MODE_NONE : MODE_LINEAR;
      end else if (ac_neg) begin
         job_in.mode = MODE_TWO;
         job_in.disc = bbx + ac4;
      end else if (bbx > ac4) begin
         job_in.mode = MODE_TWO;
         job_in.disc = bbx - ac4;
      end else if (bbx == ac4) begin
         job_in.mode = MODE_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sm_a_ff <= sm_a_in;
         sm_b_ff <= sm_a_ff;
         bb_ff   <= bb_in;
         ac_ff   <= ac_in;
         job_ff  <= job_in;
      end
   end

endmodule

>>> design/qrs_queue.sv
// ----------------------------------------------------------------------------
// Quadratic root solver job queue
// Four-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  qrs_pkg::job_type push_data,
   output logic             full,
   output logic             pop_valid,
   output qrs_pkg::job_type pop_data,
   input  logic             pop
);
   import qrs_pkg::*;

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   job_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ff, rd_ff;
   logic [AW:0]    cnt_ff;
   logic           push;

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];
   assign push      = push_valid && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> design/qrs_back.sv
// ----------------------------------------------------------------------------
// Quadratic root solver back end
// Pipelined square root of the discriminant, one root bit per stage, then
// two pipelined restoring dividers, one quotient bit per stage, and the
// saturating output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  qrs_pkg::job_type job_data,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qrs_pkg::rsp_type rsp_data
);
   import qrs_pkg::*;

   localparam int W  = COEF_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int DW = DISC_WIDTH;
   localparam int SW = SQRT_WIDTH;
   localparam int NW = W + 1;
   localparam int XW = NW + F;
   localparam int TW = DW + 2;

   typedef struct packed {
      mode_type       mode;
      logic           b_neg;
      logic [W-1:0]   b_mag;
      logic           a_neg;
      logic [W:0]     dvs;
      logic           lin_neg;
      logic [W-1:0]   c_mag;
      logic [DW-1:0]  rem;
      logic [SW-1:0]  root;
   } sq_type;

   typedef struct packed {
      mode_type       mode;
      logic           neg1;
      logic           neg2;
      logic [W:0]     dvs;
      logic [W:0]     rem1;
      logic [W:0]     rem2;
      logic [XW-1:0]  acc1;
      logic [XW-1:0]  acc2;
   } dv_type;

   function automatic sq_type sq_step(sq_type s, int k);
      logic [TW-1:0] trial;
      sq_type        r;
      r     = s;
      trial = (TW'(s.root) << (k + 1)) | (TW'(1) << (2 * k));
      if (TW'(s.rem) >= trial) begin
         r.rem  = s.rem - trial[DW-1:0];
         r.root = s.root | (SW'(1) << k);
      end
      return r;
   endfunction

   function automatic dv_type dv_init(sq_type s);
      logic signed [W+2:0] nb, sx, n1, n2;
      logic [W+2:0]        m1, m2;
      dv_type              r;
      nb = s.b_neg ? $signed({3'b000, s.b_mag}) : -$signed({3'b000, s.b_mag});
      sx = $signed({2'b00, s.root});
      n1 = nb + sx;
      n2 = nb - sx;
      m1 = n1[W+2] ? (W+3)'(-n1) : (W+3)'(n1);
      m2 = n2[W+2] ? (W+3)'(-n2) : (W+3)'(n2);
      r.mode = s.mode;
      r.dvs  = s.dvs;
      r.rem1 = '0;
      r.rem2 = '0;
      case (s.mode) inside
         MODE_LINEAR: begin
            r.acc1 = {NW'(s.c_mag), {F{1'b0}}};
            r.neg1 = s.lin_neg;
            r.acc2 = '0;
            r.neg2 = 1'b0;
         end
         MODE_ONE, MODE_TWO: begin
            r.acc1 = {m1[NW-1:0], {F{1'b0}}};
            r.neg1 = n1[W+2] ^ s.a_neg;
            r.acc2 = {m2[NW-1:0], {F{1'b0}}};
            r.neg2 = n2[W+2] ^ s.a_neg;
         end
         default: begin
            r.acc1 = '0;
            r.neg1 = 1'b0;
            r.acc2 = '0;
            r.neg2 = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic dv_type dv_step(dv_type s);
      logic [W+1:0] t1, t2, d;
      dv_type       r;
      r  = s;
      d  = {1'b0, s.dvs};
      t1 = {s.rem1, s.acc1[XW-1]};
      t2 = {s.rem2, s.acc2[XW-1]};
      if (t1 >= d) begin
         r.rem1 = (W+1)'(t1 - d);
         r.acc1 = {s.acc1[XW-2:0], 1'b1};
      end else begin
         r.rem1 = t1[W:0];
         r.acc1 = {s.acc1[XW-2:0], 1'b0};
      end
      if (t2 >= d) begin
         r.rem2 = (W+1)'(t2 - d);
         r.acc2 = {s.acc2[XW-2:0], 1'b1};
      end else begin
         r.rem2 = t2[W:0];
         r.acc2 = {s.acc2[XW-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [W:0] clamp(logic neg, logic [XW-1:0] q);
      logic [XW-1:0] lim, m;
      logic          sat;
      lim = neg ? (XW'(1) << (W - 1)) : ((XW'(1) << (W - 1)) - XW'(1));
      sat = (q > lim);
      m   = sat ? lim : q;
      return {sat, (neg ? W'(XW'(0) - m) : W'(m))};
   endfunction

   logic            adv;
   logic [SW:0]     sq_valid_ff;
   logic [XW:0]     dv_valid_ff;
   logic            rsp_valid_ff;
   sq_type          sq_ff [SW+1];
   sq_type          sq_in [SW+1];
   dv_type          dv_ff [XW+1];
   dv_type          dv_in [XW+1];
   rsp_type         rsp_ff, rsp_in;
   logic [W:0]      c1, c2;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign job_pop   = adv && job_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sq_in[0].mode    = job_data.mode;
      sq_in[0].b_neg   = job_data.b_neg;
      sq_in[0].b_mag   = job_data.b_mag;
      sq_in[0].a_neg   = job_data.a_neg;
      sq_in[0].dvs     = job_data.dvs;
      sq_in[0].lin_neg = job_data.lin_neg;
      sq_in[0].c_mag   = job_data.c_mag;
      sq_in[0].rem     = job_data.disc;
      sq_in[0].root    = '0;
      for (int i = 0; i < SW; i++) begin
         sq_in[i+1] = sq_step(sq_ff[i], SW - 1 - i);
      end
      dv_in[0] = dv_init(sq_ff[SW]);
      for (int j = 0; j < XW; j++) begin
         dv_in[j+1] = dv_step(dv_ff[j]);
      end
   end

   always_comb begin
      c1 = clamp(dv_ff[XW].neg1, dv_ff[XW].acc1);
      c2 = clamp(dv_ff[XW].neg2, dv_ff[XW].acc2);
      rsp_in.root_count  = COUNT_NONE;
      rsp_in.root_first  = '0;
      rsp_in.root_second = '0;
      rsp_in.saturated   = 1'b0;
      case (dv_ff[XW].mode) inside
         MODE_LINEAR, MODE_ONE: begin
            rsp_in.root_count = COUNT_ONE;
            rsp_in.root_first = c1[W-1:0];
            rsp_in.saturated  = c1[W];
         end
         MODE_TWO: begin
            rsp_in.root_count  = COUNT_TWO;
            rsp_in.root_first  = c1[W-1:0];
            rsp_in.root_second = c2[W-1:0];
            rsp_in.saturated   = c1[W] | c2[W];
         end
         default: begin
            rsp_in.root_count = COUNT_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= '0;
         dv_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         sq_valid_ff  <= {sq_valid_ff[SW-1:0], job_valid};
         dv_valid_ff  <= {dv_valid_ff[XW-1:0], sq_valid_ff[SW]};
         rsp_valid_ff <= dv_valid_ff[XW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= SW; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         for (int j = 0; j <= XW; j++) begin
            dv_ff[j] <= dv_in[j];
         end
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> design/quadratic_root_solver_unit.sv
// ----------------------------------------------------------------------------
// Quadratic root solver unit
// Real roots of a*x^2 + b*x + c = 0 for signed Q16.16 coefficients.
//
//   Channel   Ports                              Carries
//   request   req_valid, req_stall, req_data     coefficients a, b, c
//   response  rsp_valid, rsp_stall, rsp_data     count, two roots, saturation
//
// One request is accepted every cycle while the response side keeps up.
// A response follows its request through the front end, the queue, the
// 33-stage square root, the 49-stage dividers and the output register.
// Reset clears only the valid bits of the pipeline and output and the queue's pointers and count.
// A response stall freezes the back end, the queue fills, and then the
// front end raises req_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadratic_root_solver_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qrs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qrs_pkg::rsp_type rsp_data
);
   import qrs_pkg::*;

   logic    job_valid, job_full, pop_valid, job_pop;
   job_type job_data, pop_data;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_full  (job_full)
   );

   qrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (job_valid),
      .push_data  (job_data),
      .full       (job_full),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (job_pop)
   );

   qrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_data  (pop_data),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Drives coefficient requests with random idle and stall patterns. A short
// table of directed requests comes first, then random requests. Each response
// is compared field by field with a typed expectation or a bit-exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import qrs_pkg::*;

   localparam int RANDOM_REQUESTS = 1830;
   localparam int CYCLE_LIMIT     = 600000;
   localparam logic [31:0] ONE_Q  = 32'h0001_0000;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type     pending_roots[$];
   int          mismatches = 0;
   int          responses = 0;
   int          cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   quadratic_root_solver_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] clamp_root(bit neg, logic [127:0] q, ref bit sat);
      logic [127:0] limit;
      logic [31:0]  m;
      limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > limit) begin
         q = limit;
         sat = 1'b1;
      end
      m = q[31:0];
      return neg ? -m : m;
   endfunction

   function automatic logic [31:0] quad_div(logic signed [63:0] n, bit a_neg,
                                            logic [31:0] a_mag, ref bit sat);
      logic [127:0] n_mag;
      logic [127:0] q;
      n_mag = (n < 0) ? {64'b0, -n} : {64'b0, n};
      q = (n_mag << FRAC_BITS) / ({96'b0, a_mag} << 1);
      return clamp_root((n < 0) != a_neg, q, sat);
   endfunction

   function automatic rsp_type solve_roots(req_type r);
      rsp_type          o;
      bit               an, bn, cn, sat;
      logic [31:0]      am, bm, cm;
      logic [127:0]     b2, ac4, disc, root, t;
      logic signed [63:0] bval, s;
      int               dsign;
      an = r.coef_a[31];
      bn = r.coef_b[31];
      cn = r.coef_c[31];
      am = an ? -r.coef_a : r.coef_a;
      bm = bn ? -r.coef_b : r.coef_b;
      cm = cn ? -r.coef_c : r.coef_c;
      sat = 1'b0;
      o = '0;
      if (am == 0) begin
         if (bm != 0) begin
            o.root_count = COUNT_ONE;
            o.root_first = clamp_root(cm != 0 && cn == bn,
                                      ({96'b0, cm} << FRAC_BITS) / {96'b0, bm}, sat);
         end
      end else begin
         b2   = {96'b0, bm} * {96'b0, bm};
         ac4  = ({96'b0, am} * {96'b0, cm}) << 2;
         disc = 0;
         if (an != cn && cm != 0) begin
            dsign = 1;
            disc = b2 + ac4;
         end else begin
            dsign = (b2 > ac4) ? 1 : (b2 == ac4) ? 0 : -1;
            if (dsign > 0) disc = b2 - ac4;
         end
         bval = bn ? -$signed({32'b0, bm}) : $signed({32'b0, bm});
         if (dsign > 0) begin
            root = 0;
            for (int k = 52; k >= 0; k--) begin
               t = root | (128'b1 << k);
               if (t * t <= disc) root = t;
            end
            s = root[63:0];
            o.root_count  = COUNT_TWO;
            o.root_first  = quad_div(-bval + s, an, am, sat);
            o.root_second = quad_div(-bval - s, an, am, sat);
         end else if (dsign == 0) begin
            o.root_count = COUNT_ONE;
            o.root_first = quad_div(-bval, an, am, sat);
         end
      end
      o.saturated = sat;
      return o;
   endfunction

   function automatic logic [31:0] any_coef();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $signed($urandom_range(8191)) - 4096;
         2: return 32'h0;
         3: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
         default: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
      endcase
   endfunction

   function automatic req_type random_coefs();
      req_type     r;
      logic [31:0] m, t;
      case ($urandom_range(9))
         0, 1: begin
            r.coef_a = $urandom;
            r.coef_b = $urandom;
            r.coef_c = $urandom;
         end
         2: begin
            m = $signed($urandom_range(4095)) - 2048;
            if (m == 0) m = 1;
            t = $signed($urandom_range(255)) - 128;
            r.coef_a = m;
            r.coef_b = 2 * m * t;
            r.coef_c = m * t * t;
         end
         3: begin
            r.coef_a = 0;
            r.coef_b = any_coef();
            r.coef_c = any_coef();
         end
         default: begin
            r.coef_a = any_coef();
            r.coef_b = any_coef();
            r.coef_c = any_coef();
         end
      endcase
      return r;
   endfunction

   task automatic send_request(req_type r, rsp_type expected);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_roots.push_back(expected);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_roots.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            rsp_type e;
            e = pending_roots.pop_front();
            responses++;
            if (rsp_data.root_count !== e.root_count) begin
               $error("root_count expected %0d actual %0d", e.root_count,
                      rsp_data.root_count);
               mismatches++;
            end
            if (rsp_data.root_first !== e.root_first) begin
               $error("root_first expected %h actual %h", e.root_first,
                      rsp_data.root_first);
               mismatches++;
            end
            if (rsp_data.root_second !== e.root_second) begin
               $error("root_second expected %h actual %h", e.root_second,
                      rsp_data.root_second);
               mismatches++;
            end
            if (rsp_data.saturated !== e.saturated) begin
               $error("saturated expected %b actual %b", e.saturated,
                      rsp_data.saturated);
               mismatches++;
            end
         end
      end
   end

   initial begin
      stim_row_type table_rows[$];
      int           wait_cycles;
      req_type      r;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      table_rows = '{
         '{'{32'h0, 32'h0, 32'h0}, 1, '{COUNT_NONE, 32'h0, 32'h0, 1'b0}},
         '{'{32'h0, 32'h0, 32'h5}, 1, '{COUNT_NONE, 32'h0, 32'h0, 1'b0}},
         '{'{32'h0, ONE_Q, -32'sh2_0000}, 1, '{COUNT_ONE, 32'h2_0000, 32'h0, 1'b0}},
         '{'{ONE_Q, 32'h0, -ONE_Q}, 1, '{COUNT_TWO, ONE_Q, -ONE_Q, 1'b0}},
         '{'{ONE_Q, -32'sh2_0000, ONE_Q}, 1, '{COUNT_ONE, ONE_Q, 32'h0, 1'b0}},
         '{'{ONE_Q, 32'h0, ONE_Q}, 1, '{COUNT_NONE, 32'h0, 32'h0, 1'b0}},
         '{'{32'h0, 32'h1, 32'h7FFF_FFFF}, 1,
           '{COUNT_ONE, 32'h8000_0000, 32'h0, 1'b1}},
         '{'{32'h0, -32'sh1, 32'h7FFF_FFFF}, 1,
           '{COUNT_ONE, 32'h7FFF_FFFF, 32'h0, 1'b1}},
         '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0, '0},
         '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, '0},
         '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0, '0},
         '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, '0},
         '{'{32'h1, 32'h7FFF_FFFF, 32'h8000_0000}, 0, '0},
         '{'{32'h1, 32'h0, 32'h8000_0000}, 0, '0},
         '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1}, 0, '0},
         '{'{32'h0, 32'h8000_0000, 32'h7FFF_FFFF}, 0, '0},
         '{'{32'h0, 32'h7FFF_FFFF, 32'h0}, 0, '0},
         '{'{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF}, 0, '0},
         '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 0, '0},
         '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 0, '0}
      };
      foreach (table_rows[i])
         send_request(table_rows[i].req, table_rows[i].typed ? table_rows[i].rsp
                                                           : solve_roots(table_rows[i].req));

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 0) begin
            send_idle_pct = 30;
            recv_stall_pct = 77;
         end else if (n == RANDOM_REQUESTS / 3) begin
            send_idle_pct = 77;
            recv_stall_pct = 30;
         end else if (n == 2 * RANDOM_REQUESTS / 3) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         r = random_coefs();
         send_request(r, solve_roots(r));
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending_roots.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      $display("Checked %0d responses from %0d directed and %0d random requests,",
               responses, table_rows.size(), RANDOM_REQUESTS);
      $display("under sender idling and receiver stalling in both orders and none.");
      if (mismatches == 0 && pending_roots.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/qrs_pkg.sv
design/qrs_front.sv
design/qrs_queue.sv
design/qrs_back.sv
design/quadratic_root_solver_unit.sv
tb/sv/testbench.sv
